>>> src/clst_pkg.sv
// Package for the C-like source tokenizer: result record, kind and error codes,
// lexer modes and character class helpers. No dependencies.
`default_nettype none
package clst_pkg;

    localparam int LINE_W = 24;
    localparam int COL_W  = 16;
    localparam int LEN_W  = 16;
    localparam int VAL_W  = 63;
    localparam int POS_OUT_W = 24;

    localparam int DEF_MAX_COMMENT_NEST = 15;
    localparam int DEF_POSITION_BITS    = 24;

    localparam logic [2:0] K_IDENT = 3'd0;
    localparam logic [2:0] K_INT   = 3'd1;
    localparam logic [2:0] K_FLOAT = 3'd2;
    localparam logic [2:0] K_STR   = 3'd3;
    localparam logic [2:0] K_CHAR  = 3'd4;
    localparam logic [2:0] K_PUNCT = 3'd5;
    localparam logic [2:0] K_END   = 3'd6;
    localparam logic [2:0] K_DIAG  = 3'd7;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_BADCHAR = 3'd1;
    localparam logic [2:0] E_OPENCMT = 3'd2;
    localparam logic [2:0] E_HEXLET  = 3'd3;
    localparam logic [2:0] E_HEXEMPT = 3'd4;
    localparam logic [2:0] E_OCTDIG  = 3'd5;
    localparam logic [2:0] E_CHRLEN  = 3'd6;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    localparam logic [63:0] VAL_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    // lexer modes, one-hot
    typedef enum logic [10:0] {
        M_IDLE   = 11'b000_0000_0001,
        M_IDENT  = 11'b000_0000_0010,
        M_DEC    = 11'b000_0000_0100,
        M_OCT    = 11'b000_0000_1000,
        M_HEX    = 11'b000_0001_0000,
        M_STR    = 11'b000_0010_0000,
        M_CHR    = 11'b000_0100_0000,
        M_LINEC  = 11'b000_1000_0000,
        M_BLOCKC = 11'b001_0000_0000,
        M_PEND   = 11'b010_0000_0000,
        M_ANGLE2 = 11'b100_0000_0000
    } mode_t;

    // one result record
    typedef struct packed {
        logic [2:0]        kind;
        logic [2:0]        err;
        logic [23:0]       pos;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  val;
        logic [7:0]        cv;
    } result_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic pend_start(input logic [7:0] b);
        return b == "/" || b == "+" || b == "-" || b == "*" || b == "%" || b == "&" ||
               b == "|" || b == "^" || b == "<" || b == ">" || b == "=" || b == ":" ||
               b == "!" || b == ".";
    endfunction

    function automatic logic single_punct(input logic [7:0] b);
        return b == "~" || b == "#" || b == "," || b == ";" || b == "?" || b == "@" ||
               b == "(" || b == ")" || b == "[" || b == "]" || b == "{" || b == "}";
    endfunction

endpackage
`default_nettype wire

>>> src/c_like_source_tokenizer.sv
// Top level of the C-like source tokenizer: byte stream in, token stream out.
// Depends on clst_pkg.
//
//  channel | dir | handshake          | payload
//  s_      | in  | tvalid/tready      | tdata[7:0] text_byte
//  m_      | out | tvalid/tready/tlast| tdata: kind,err,pos,line,col,len,val,cv; tlast last_of_run
//
// One byte is taken per cycle when the result queue has room; the byte's whole
// lexer update is combinational and its up to three results land in a
// small output queue drained one beat per cycle while m_tready is high. So a
// byte that yields two or three results can hold the input back until the queue drains.
// aresetn is synchronous, active low; it returns all counters to the start of text.
// A stall on m_ holds s_tready low once the queue cannot take three more results.
`default_nettype none
module c_like_source_tokenizer #(
    parameter int MAX_COMMENT_NEST = clst_pkg::DEF_MAX_COMMENT_NEST,
    parameter int POSITION_BITS    = clst_pkg::DEF_POSITION_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // text_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // kind[2:0] err[5:3] pos[29:6] line[53:30] col[69:54] len[85:70]
    // val[148:86] cv[156:149], zero fill to 160
    output logic [159:0]      m_tdata,
    output logic              m_tlast    // last_of_run
);
    import clst_pkg::*;

    localparam int PW = POSITION_BITS;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
    localparam int DW = $clog2(MAX_COMMENT_NEST + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_COMMENT_NEST);
    localparam int QD = 4;

    // lexer state
    mode_t             mode_reg, mode_next;
    logic [7:0]        la_reg, la_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     tpos_reg, tpos_next;
    logic [LINE_W-1:0] tline_reg, tline_next;
    logic [COL_W-1:0]  tcol_reg, tcol_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [63:0]       acc_reg, acc_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic              cr_reg, cr_next;
    logic              stop_reg, stop_next;
    logic              fp_reg, fp_next;

    // output queue
    result_t           q_mem [QD];
    logic              q_last [QD];
    logic [1:0]        rd_reg, wr_reg;
    logic [2:0]        cnt_reg;

    result_t           res [3];
    logic [1:0]        nres;
    logic              take, pop;
    logic              endf;
    logic [7:0]        b;

    assign b        = s_tdata;
    assign s_tready = (cnt_reg <= 3'd1) || (cnt_reg == 3'd2 && pop) || (cnt_reg == 3'd4 && 1'b0);
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = cnt_reg != 3'd0;
    assign pop      = m_tvalid && m_tready;

    function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] v);
        return (v == {COL_W{1'b1}}) ? v : v + 1'b1;
    endfunction
    function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] v);
        return (v == {LEN_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // saturating base*acc + d, base ten, eight or sixteen chosen by the caller
    function automatic logic [63:0] accum(input logic [63:0] a, input logic [1:0] base,
                                          input logic [3:0] d);
        logic [67:0] m;
        logic [67:0] s;
        begin
            unique case (base)
                2'd0:    m = {4'd0, a} * 68'd10;
                2'd1:    m = {a, 3'd0} | 68'd0;
                default: m = {a, 4'd0};
            endcase
            s = m + {64'd0, d};
            return (s > {4'd0, VAL_TOP}) ? VAL_TOP : s[63:0];
        end
    endfunction

    // lexer update for one byte
    always_comb begin
        result_t r_here, r_tok;
        logic    restart, skip;
        logic    pend_two;
        logic [7:0] p;
        mode_next  = mode_reg;
        la_next    = la_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        tpos_next  = tpos_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        depth_next = depth_reg;
        cr_next    = cr_reg;
        stop_next  = stop_reg;
        fp_next    = fp_reg;
        endf       = 1'b0;
        nres       = 2'd0;
        restart    = 1'b0;
        skip       = 1'b0;
        pend_two   = 1'b0;
        p          = la_reg;
        for (int i = 0; i < 3; i++) res[i] = '0;

        r_here = '0;
        r_here.pos  = POS_OUT_W'(pos_reg);
        r_here.line = line_reg;
        r_here.col  = col_reg;
        r_tok = '0;
        r_tok.pos  = POS_OUT_W'(tpos_reg);
        r_tok.line = tline_reg;
        r_tok.col  = tcol_reg;
        r_tok.len  = len_reg;

        if (cr_reg) begin
            cr_next = 1'b0;
            if (b == CH_LF) skip = 1'b1;
        end

        if (skip) begin
            pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        end else begin
            unique case (mode_reg)
                M_IDENT: begin
                    if (is_alpha(b) || is_digit(b) || b == "_") len_next = len_inc(len_reg);
                    else begin
                        res[nres] = r_tok; res[nres].kind = K_IDENT; res[nres].cv = la_reg;
                        nres = nres + 1'b1; restart = 1'b1;
                    end
                end
                M_DEC: begin
                    if (is_digit(b)) begin
                        len_next = len_inc(len_reg);
                        if (!fp_reg && !stop_reg) acc_next = accum(acc_reg, 2'd0, b[3:0]);
                    end else if (b == "." && !fp_reg) begin
                        fp_next = 1'b1; len_next = len_inc(len_reg);
                    end else begin
                        res[nres] = r_tok; res[nres].cv = la_reg;
                        res[nres].kind = fp_reg ? K_FLOAT : K_INT;
                        if (!fp_reg) res[nres].val = acc_reg[VAL_W-1:0];
                        nres = nres + 1'b1; restart = 1'b1;
                    end
                end
                M_OCT: begin
                    if (len_reg == LEN_W'(1) && (b == "x" || b == "X")) begin
                        len_next = LEN_W'(2); mode_next = M_HEX;
                    end else if (is_digit(b)) begin
                        len_next = len_inc(len_reg);
                        if (b > "7") begin
                            res[nres] = r_here; res[nres].kind = K_DIAG;
                            res[nres].err = E_OCTDIG; res[nres].len = LEN_W'(1);
                            res[nres].cv = b; nres = nres + 1'b1; stop_next = 1'b1;
                        end else if (!stop_reg) acc_next = accum(acc_reg, 2'd1, b[3:0]);
                    end else begin
                        res[nres] = r_tok; res[nres].kind = K_INT; res[nres].cv = la_reg;
                        res[nres].val = acc_reg[VAL_W-1:0];
                        nres = nres + 1'b1; restart = 1'b1;
                    end
                end
                M_HEX: begin
                    if (is_alpha(b) || is_digit(b)) begin
                        len_next = len_inc(len_reg);
                        if (is_digit(b)) begin
                            if (!stop_reg) acc_next = accum(acc_reg, 2'd2, b[3:0]);
                        end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
                            if (!stop_reg) acc_next = accum(acc_reg, 2'd2, b[3:0] + 4'd9);
                        end else begin
                            res[nres] = r_here; res[nres].kind = K_DIAG;
                            res[nres].err = E_HEXLET; res[nres].len = LEN_W'(1);
                            res[nres].cv = b; nres = nres + 1'b1; stop_next = 1'b1;
                        end
                    end else begin
                        if (len_reg == LEN_W'(2)) begin
                            res[nres] = r_tok; res[nres].kind = K_DIAG;
                            res[nres].err = E_HEXEMPT; res[nres].len = LEN_W'(1);
                            res[nres].pos = POS_OUT_W'((tpos_reg == POS_MAX) ? tpos_reg
                                                       : tpos_reg + 1'b1);
                            res[nres].col = col_inc(tcol_reg);
                            nres = nres + 1'b1;
                        end
                        res[nres] = r_tok; res[nres].kind = K_INT; res[nres].cv = la_reg;
                        res[nres].val = acc_reg[VAL_W-1:0];
                        nres = nres + 1'b1; restart = 1'b1;
                    end
                end
                M_STR: begin
                    if (b == "\"") begin
                        res[nres] = r_tok; res[nres].kind = K_STR; res[nres].cv = la_reg;
                        nres = nres + 1'b1; mode_next = M_IDLE;
                    end else if (b == 8'd0) begin
                        res[nres] = r_tok; res[nres].kind = K_END;
                        nres = nres + 1'b1; endf = 1'b1;
                    end else begin
                        if (len_reg == '0) la_next = b;
                        len_next = len_inc(len_reg);
                    end
                end
                M_CHR: begin
                    if (b == "'" || b == 8'd0) begin
                        if (len_reg == LEN_W'(1)) begin
                            res[nres] = r_tok; nres = nres + 1'b1;
                            if (b == 8'd0) begin
                                res[0].kind = K_END; endf = 1'b1;
                            end else begin
                                res[0].kind = K_CHAR; res[0].cv = la_reg;
                                mode_next = M_IDLE;
                            end
                        end else begin
                            res[0] = r_tok; res[0].kind = K_DIAG; res[0].err = E_CHRLEN;
                            res[1] = r_tok; res[1].kind = K_CHAR;
                            nres = 2'd2;
                            if (b == 8'd0) restart = 1'b1;
                            else mode_next = M_IDLE;
                        end
                    end else begin
                        if (len_reg == '0) la_next = b;
                        len_next = len_inc(len_reg);
                    end
                end
                M_LINEC: begin
                    if (b == CH_LF || b == CH_CR) mode_next = M_IDLE;
                    else if (b == 8'd0) restart = 1'b1;
                end
                M_BLOCKC: begin
                    if (b == 8'd0) begin
                        res[nres] = r_here; res[nres].kind = K_DIAG; res[nres].err = E_OPENCMT;
                        nres = nres + 1'b1; depth_next = '0; restart = 1'b1;
                    end else if (la_reg == "/" && b == "*") begin
                        if (depth_reg < DEPTH_MAX) depth_next = depth_reg + 1'b1;
                        la_next = 8'd0;
                    end else if (la_reg == "*" && b == "/") begin
                        la_next = 8'd0;
                        if (depth_reg != '0) depth_next = depth_reg - 1'b1;
                        if (depth_reg <= DW'(1)) mode_next = M_IDLE;
                    end else begin
                        la_next = (b == "*" || b == "/") ? b : 8'd0;
                    end
                end
                M_PEND: begin
                    priority case (1'b1)
                        p == "/" && b == "/": mode_next = M_LINEC;
                        p == "/" && b == "*": begin
                            mode_next = M_BLOCKC; depth_next = DW'(1); la_next = 8'd0;
                        end
                        p == "." && is_digit(b): begin
                            mode_next = M_DEC; fp_next = 1'b1; len_next = LEN_W'(2);
                        end
                        p == "!" && b == "=": begin
                            res[0] = r_tok; res[0].kind = K_PUNCT; res[0].len = LEN_W'(2);
                            res[0].cv = p; nres = 2'd1; mode_next = M_IDLE;
                        end
                        p == "!": begin
                            res[0] = r_tok; res[0].kind = K_DIAG; res[0].err = E_BADCHAR;
                            res[0].len = LEN_W'(1); res[0].cv = p; nres = 2'd1;
                            restart = 1'b1;
                        end
                        (p == "<" || p == ">") && b == p: begin
                            len_next = LEN_W'(2); mode_next = M_ANGLE2;
                        end
                        default: begin
                            if (p == ".") pend_two = 1'b0;
                            else if (p == "+") pend_two = b == "+" || b == "=";
                            else if (p == "-") pend_two = b == "-" || b == ">" || b == "=";
                            else if (p == ":") pend_two = b == "=" || b == ":";
                            else pend_two = b == "=";
                            res[0] = r_tok; res[0].kind = K_PUNCT; res[0].cv = p;
                            nres = 2'd1;
                            if (pend_two) begin
                                res[0].len = LEN_W'(2); mode_next = M_IDLE;
                            end else restart = 1'b1;
                        end
                    endcase
                end
                M_ANGLE2: begin
                    res[0] = r_tok; res[0].kind = K_PUNCT; res[0].cv = la_reg; nres = 2'd1;
                    if (b == "=") begin
                        res[0].len = LEN_W'(3); mode_next = M_IDLE;
                    end else restart = 1'b1;
                end
                default: restart = 1'b1;
            endcase

            // start of a new token at this byte
            if (restart) begin
                mode_next = M_IDLE;
                if (b == 8'd0) begin
                    res[nres] = r_here; res[nres].kind = K_END;
                    nres = nres + 1'b1; endf = 1'b1;
                end else if (is_space(b)) begin
                    mode_next = M_IDLE;
                end else if (b == "\"" || b == "'") begin
                    tpos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
                    tline_next = line_reg;
                    tcol_next  = col_inc(col_reg);
                    len_next   = '0;
                    la_next    = 8'd0;
                    mode_next  = (b == "\"") ? M_STR : M_CHR;
                end else if (is_alpha(b) || b == "_" || is_digit(b) || pend_start(b)) begin
                    tpos_next  = pos_reg;
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                    len_next   = LEN_W'(1);
                    acc_next   = '0;
                    stop_next  = 1'b0;
                    fp_next    = 1'b0;
                    la_next    = b;
                    if (is_digit(b)) begin
                        if (b == "0") mode_next = M_OCT;
                        else begin
                            mode_next = M_DEC;
                            acc_next  = {60'd0, b[3:0]};
                        end
                    end else if (pend_start(b)) mode_next = M_PEND;
                    else mode_next = M_IDENT;
                end else begin
                    res[nres] = r_here; res[nres].len = LEN_W'(1); res[nres].cv = b;
                    if (single_punct(b)) res[nres].kind = K_PUNCT;
                    else begin
                        res[nres].kind = K_DIAG; res[nres].err = E_BADCHAR;
                    end
                    nres = nres + 1'b1;
                end
            end

            // position counters
            if (endf) begin
                mode_next  = M_IDLE;
                la_next    = '0;
                line_next  = LINE_W'(1);
                col_next   = COL_W'(1);
                pos_next   = '0;
                tpos_next  = '0;
                tline_next = '0;
                tcol_next  = '0;
                len_next   = '0;
                acc_next   = '0;
                depth_next = '0;
                cr_next    = 1'b0;
                stop_next  = 1'b0;
                fp_next    = 1'b0;
            end else begin
                if (b == CH_LF || b == CH_CR) begin
                    line_next = (line_reg == {LINE_W{1'b1}}) ? line_reg : line_reg + 1'b1;
                    col_next  = COL_W'(1);
                    if (b == CH_CR) cr_next = 1'b1;
                end else col_next = col_inc(col_reg);
                pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            la_reg    <= '0;
            line_reg  <= LINE_W'(1);
            col_reg   <= COL_W'(1);
            pos_reg   <= '0;
            tpos_reg  <= '0;
            tline_reg <= '0;
            tcol_reg  <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            depth_reg <= '0;
            cr_reg    <= 1'b0;
            stop_reg  <= 1'b0;
            fp_reg    <= 1'b0;
        end else if (take) begin
            mode_reg  <= mode_next;
            la_reg    <= la_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            tpos_reg  <= tpos_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            depth_reg <= depth_next;
            cr_reg    <= cr_next;
            stop_reg  <= stop_next;
            fp_reg    <= fp_next;
        end
    end

    // result queue write
    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < nres) begin
                    q_mem[2'(wr_reg + 2'(i))]  <= res[i];
                    q_last[2'(wr_reg + 2'(i))] <= (2'(i) == nres - 2'd1);
                end
            end
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (take) wr_reg <= wr_reg + (take ? nres : 2'd0);
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + (take ? {1'b0, nres} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    assign m_tdata = {3'd0, q_mem[rd_reg].cv, q_mem[rd_reg].val, q_mem[rd_reg].len,
                      q_mem[rd_reg].col, q_mem[rd_reg].line, q_mem[rd_reg].pos,
                      q_mem[rd_reg].err, q_mem[rd_reg].kind};
    assign m_tlast = q_last[rd_reg];

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 3'd4)
        else $error("result queue overflow");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg >= 3'd3 |-> !s_tready) else $error("ready with full queue");
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_MAX) else $error("comment depth over limit");

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for c_like_source_tokenizer: a byte-level token predictor
// feeds a queue of expected result beats, compared against the m_ stream.
// Depends on clst_pkg and the c_like_source_tokenizer RTL.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import clst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        result_t    r;
        logic       last;
    } token_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic         m_tlast;

    c_like_source_tokenizer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    // pending text bytes; -1 asks the sender to wait until all tokens are back
    int          text_q[$];
    token_beat_t token_q[$];
    int          mismatches = 0;
    int          cycles = 0;

    // ---------------- token predictor state ----------------
    mode_t        lx_mode;
    logic [7:0]   lx_first;
    logic [31:0]  lx_line, lx_col, lx_pos;
    logic [31:0]  ts_pos, ts_line, ts_col;
    logic [31:0]  lx_len;
    logic [63:0]  lx_acc;
    int           lx_depth;
    logic         f_cr, f_stop, f_fp, f_end;
    token_beat_t  step_out[3];
    int           step_cnt;

    function automatic logic [31:0] inc_sat(logic [31:0] v, logic [31:0] top);
        return (v < top) ? v + 32'd1 : top;
    endfunction

    function automatic logic dgt(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic alph(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    task automatic lexer_clear();
        lx_mode = M_IDLE; lx_first = 8'd0;
        lx_line = 1; lx_col = 1; lx_pos = 0;
        ts_pos = 0; ts_line = 0; ts_col = 0;
        lx_len = 0; lx_acc = 0; lx_depth = 0;
        f_cr = 0; f_stop = 0; f_fp = 0; f_end = 0;
    endtask

    task automatic put(logic [2:0] k, logic [2:0] e, logic [31:0] p, logic [31:0] l,
                       logic [31:0] c, logic [31:0] n, logic [63:0] v, logic [7:0] cv);
        token_beat_t t;
        if (step_cnt >= 3) return;
        t.r.kind = k; t.r.err = e; t.r.pos = p[23:0]; t.r.line = l[23:0];
        t.r.col = c[15:0]; t.r.len = n[15:0]; t.r.val = v[62:0]; t.r.cv = cv;
        t.last = 1'b0;
        step_out[step_cnt] = t;
        step_cnt++;
    endtask

    task automatic put_here(logic [2:0] k, logic [2:0] e, logic [31:0] n, logic [7:0] cv);
        put(k, e, lx_pos, lx_line, lx_col, n, 64'd0, cv);
    endtask

    task automatic put_tok(logic [2:0] k, logic [63:0] v, logic [7:0] cv);
        put(k, E_NONE, ts_pos, ts_line, ts_col, lx_len, v, cv);
    endtask

    task automatic accumulate(int base, int d);
        if (f_stop) return;
        if (lx_acc > (VAL_TOP - d) / base) lx_acc = VAL_TOP;
        else lx_acc = lx_acc * base + d;
    endtask

    task automatic open_token(logic [7:0] b);
        ts_pos = lx_pos; ts_line = lx_line; ts_col = lx_col;
        lx_len = 1; lx_acc = 0; f_stop = 0; f_fp = 0; lx_first = b;
    endtask

    // first byte of a token, from the idle mode
    task automatic lex_start(logic [7:0] b);
        lx_mode = M_IDLE;
        if (b == 8'd0) begin
            put_here(K_END, E_NONE, 0, 8'd0);
            f_end = 1;
        end else if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
            return;
        end else if (alph(b) || b == "_") begin
            open_token(b);
            lx_mode = M_IDENT;
        end else if (dgt(b)) begin
            open_token(b);
            if (b == "0") begin
                lx_mode = M_OCT;
            end else begin
                lx_mode = M_DEC;
                accumulate(10, b - "0");
            end
        end else if (b == "\"" || b == "'") begin
            ts_pos = inc_sat(lx_pos, 32'hFFFFFF);
            ts_line = lx_line;
            ts_col = inc_sat(lx_col, 32'hFFFF);
            lx_len = 0; lx_first = 0;
            lx_mode = (b == "\"") ? M_STR : M_CHR;
        end else if (b inside {"/", "+", "-", "*", "%", "&", "|", "^", "<", ">", "=", ":",
                               "!", "."}) begin
            open_token(b);
            lx_mode = M_PEND;
        end else if (b inside {"~", "#", ",", ";", "?", "@", "(", ")", "[", "]", "{", "}"})
        begin
            put_here(K_PUNCT, E_NONE, 1, b);
        end else begin
            put_here(K_DIAG, E_BADCHAR, 1, b);
        end
    endtask

    // second byte after a punctuator or comment opener candidate
    task automatic lex_pend(logic [7:0] b);
        logic [7:0] p;
        logic       two;
        p = lx_first;
        two = 0;
        case (p)
            "/": begin
                if (b == "/") begin lx_mode = M_LINEC; return; end
                if (b == "*") begin
                    lx_mode = M_BLOCKC; lx_depth = 1; lx_first = 0; return;
                end
                two = (b == "=");
            end
            ".": begin
                if (dgt(b)) begin lx_mode = M_DEC; f_fp = 1; lx_len = 2; return; end
            end
            "!": begin
                if (b == "=") begin
                    lx_len = 2; put_tok(K_PUNCT, 0, p); lx_mode = M_IDLE; return;
                end
                put(K_DIAG, E_BADCHAR, ts_pos, ts_line, ts_col, 1, 0, p);
                lex_start(b);
                return;
            end
            "<", ">": begin
                if (b == p) begin lx_len = 2; lx_mode = M_ANGLE2; return; end
                two = (b == "=");
            end
            "+": two = (b == "+" || b == "=");
            "-": two = (b == "-" || b == ">" || b == "=");
            ":": two = (b == "=" || b == ":");
            default: two = (b == "=");
        endcase
        if (two) begin
            lx_len = 2; put_tok(K_PUNCT, 0, p); lx_mode = M_IDLE;
        end else begin
            put_tok(K_PUNCT, 0, p); lex_start(b);
        end
    endtask

    task automatic lex_byte(logic [7:0] b);
        logic [31:0] xp, xc;
        case (lx_mode)
            M_IDENT: begin
                if (alph(b) || dgt(b) || b == "_") begin
                    lx_len = inc_sat(lx_len, 32'hFFFF);
                end else begin
                    put_tok(K_IDENT, 0, lx_first); lex_start(b);
                end
            end
            M_DEC: begin
                if (dgt(b)) begin
                    lx_len = inc_sat(lx_len, 32'hFFFF);
                    if (!f_fp) accumulate(10, b - "0");
                end else if (b == "." && !f_fp) begin
                    f_fp = 1; lx_len = inc_sat(lx_len, 32'hFFFF);
                end else begin
                    if (f_fp) put_tok(K_FLOAT, 0, lx_first);
                    else put_tok(K_INT, lx_acc, lx_first);
                    lex_start(b);
                end
            end
            M_OCT: begin
                if (lx_len == 1 && (b == "x" || b == "X")) begin
                    lx_len = 2; lx_mode = M_HEX;
                end else if (dgt(b)) begin
                    lx_len = inc_sat(lx_len, 32'hFFFF);
                    if (b > "7") begin put_here(K_DIAG, E_OCTDIG, 1, b); f_stop = 1; end
                    else accumulate(8, b - "0");
                end else begin
                    put_tok(K_INT, lx_acc, lx_first); lex_start(b);
                end
            end
            M_HEX: begin
                if (alph(b) || dgt(b)) begin
                    lx_len = inc_sat(lx_len, 32'hFFFF);
                    if (dgt(b)) accumulate(16, b - "0");
                    else if (b >= "a" && b <= "f") accumulate(16, b - "a" + 10);
                    else if (b >= "A" && b <= "F") accumulate(16, b - "A" + 10);
                    else begin put_here(K_DIAG, E_HEXLET, 1, b); f_stop = 1; end
                end else begin
                    if (lx_len == 2) begin
                        xp = inc_sat(ts_pos, 32'hFFFFFF);
                        xc = inc_sat(ts_col, 32'hFFFF);
                        put(K_DIAG, E_HEXEMPT, xp, ts_line, xc, 1, 0, 8'd0);
                    end
                    put_tok(K_INT, lx_acc, lx_first); lex_start(b);
                end
            end
            M_STR: begin
                if (b == "\"") begin
                    put_tok(K_STR, 0, lx_first); lx_mode = M_IDLE;
                end else if (b == 8'd0) begin
                    put_tok(K_END, 0, 8'd0); f_end = 1;
                end else begin
                    if (lx_len == 0) lx_first = b;
                    lx_len = inc_sat(lx_len, 32'hFFFF);
                end
            end
            M_CHR: begin
                if (b == "'" || b == 8'd0) begin
                    if (lx_len == 1) begin
                        if (b == 8'd0) begin put_tok(K_END, 0, 8'd0); f_end = 1; end
                        else begin put_tok(K_CHAR, 0, lx_first); lx_mode = M_IDLE; end
                    end else begin
                        put(K_DIAG, E_CHRLEN, ts_pos, ts_line, ts_col, lx_len, 0, 8'd0);
                        put_tok(K_CHAR, 0, 8'd0);
                        if (b == 8'd0) lex_start(8'd0);
                        else lx_mode = M_IDLE;
                    end
                end else begin
                    if (lx_len == 0) lx_first = b;
                    lx_len = inc_sat(lx_len, 32'hFFFF);
                end
            end
            M_LINEC: begin
                if (b == CH_LF || b == CH_CR) lx_mode = M_IDLE;
                else if (b == 8'd0) lex_start(8'd0);
            end
            M_BLOCKC: begin
                if (b == 8'd0) begin
                    put_here(K_DIAG, E_OPENCMT, 0, 8'd0);
                    lx_depth = 0;
                    lex_start(8'd0);
                end else if (lx_first == "/" && b == "*") begin
                    if (lx_depth < DEF_MAX_COMMENT_NEST) lx_depth++;
                    lx_first = 0;
                end else if (lx_first == "*" && b == "/") begin
                    if (lx_depth > 0) lx_depth--;
                    lx_first = 0;
                    if (lx_depth == 0) lx_mode = M_IDLE;
                end else begin
                    lx_first = (b == "*" || b == "/") ? b : 8'd0;
                end
            end
            M_PEND: lex_pend(b);
            M_ANGLE2: begin
                if (b == "=") begin
                    lx_len = 3; put_tok(K_PUNCT, 0, lx_first); lx_mode = M_IDLE;
                end else begin
                    put_tok(K_PUNCT, 0, lx_first); lex_start(b);
                end
            end
            default: lex_start(b);
        endcase
    endtask

    // one accepted text byte: queue the tokens it produces
    task automatic predict_tokens(logic [7:0] b);
        step_cnt = 0;
        if (f_cr) begin
            f_cr = 0;
            if (b == CH_LF) begin
                lx_pos = inc_sat(lx_pos, 32'hFFFFFF);
                return;
            end
        end
        lex_byte(b);
        if (f_end) begin
            lexer_clear();
        end else begin
            if (b == CH_LF || b == CH_CR) begin
                lx_line = inc_sat(lx_line, 32'hFFFFFF);
                lx_col = 1;
                if (b == CH_CR) f_cr = 1;
            end else begin
                lx_col = inc_sat(lx_col, 32'hFFFF);
            end
            lx_pos = inc_sat(lx_pos, 32'hFFFFFF);
        end
        if (step_cnt > 0) step_out[step_cnt-1].last = 1'b1;
        for (int i = 0; i < step_cnt; i++) token_q.push_back(step_out[i]);
    endtask

    // ---------------- stimulus ----------------
    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic push_digits(int n, int lo, int hi);
        for (int i = 0; i < n; i++) text_q.push_back($urandom_range(lo, hi));
    endtask

    task automatic push_ident();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: text_q.push_back($urandom_range("a", "z"));
                1: text_q.push_back($urandom_range("A", "Z"));
                2: text_q.push_back("_");
                default: text_q.push_back(i == 0 ? "q" : $urandom_range("0", "9"));
            endcase
        end
    endtask

    task automatic push_random_token();
        string puncts[$] = '{"+", "-", "*", "/", "%", "~", "&", "|", "^", "<", ">", "=",
                             "#", ".", ",", ":", ";", "?", "@", "(", ")", "[", "]",
                             "{", "}", "!", "++", "--", "->", "::", ":=", "==", "!=",
                             "<<", ">>", "<<=", ">>=", "+=", "&&", "||", "<=", "/="};
        case ($urandom_range(0, 15))
            0, 1: push_ident();
            2: begin
                text_q.push_back($urandom_range("1", "9"));
                push_digits($urandom_range(0, 22), "0", "9");
            end
            3: begin
                text_q.push_back("0");
                push_digits($urandom_range(0, 23), "0", ($urandom_range(0, 3) == 0) ? "9" : "7");
            end
            4: begin
                push_text($urandom_range(0, 1) ? "0x" : "0X");
                for (int i = $urandom_range(0, 17); i > 0; i--)
                    case ($urandom_range(0, 5))
                        0: text_q.push_back($urandom_range("g", "z"));
                        1: text_q.push_back($urandom_range("A", "F"));
                        2: text_q.push_back($urandom_range("a", "f"));
                        default: text_q.push_back($urandom_range("0", "9"));
                    endcase
            end
            5: begin
                push_digits($urandom_range(0, 3), "0", "9");
                text_q.push_back(".");
                push_digits($urandom_range(1, 3), "0", "9");
                if ($urandom_range(0, 3) == 0) push_text(".5");
            end
            6: begin
                text_q.push_back("\"");
                for (int i = $urandom_range(0, 5); i > 0; i--)
                    text_q.push_back($urandom_range(32, 126) == "\"" ? "x" : $urandom_range(32, 255));
                text_q.push_back("\"");
            end
            7: begin
                text_q.push_back("'");
                for (int i = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1; i > 0; i--)
                    text_q.push_back($urandom_range(32, 126) == "'" ? "c" : $urandom_range(32, 126));
                text_q.push_back("'");
            end
            8, 9: push_text(puncts[$urandom_range(0, puncts.size() - 1)]);
            10: begin
                push_text("/*");
                for (int i = $urandom_range(0, 8); i > 0; i--)
                    case ($urandom_range(0, 3))
                        0: push_text("/*");
                        1: push_text("*/");
                        default: text_q.push_back($urandom_range(1, 255));
                    endcase
                push_text("*/*/");
            end
            11: begin
                push_text("//");
                push_digits($urandom_range(0, 5), 1, 255);
                text_q.push_back(CH_LF);
            end
            12: text_q.push_back($urandom_range(1, 255));
            13: push_text($urandom_range(0, 1) ? "\r\n" : "\r");
            14: text_q.push_back($urandom_range(0, 30) == 0 ? 0 : 9);
            default: text_q.push_back(" ");
        endcase
        if ($urandom_range(0, 2) == 0) text_q.push_back(" ");
    endtask

    // ---------------- sender ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        logic       next_valid;
        logic [7:0] next_byte;
        next_valid = s_tvalid;
        next_byte = s_tdata;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_tokens(s_tdata);
            if (!s_tvalid || s_tready) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (text_q.size() > 0 && text_q[0] < 0) begin
                    if (token_q.size() == 0) void'(text_q.pop_front());
                end else if (text_q.size() > 0) begin
                    next_valid = 1'b1;
                    next_byte = 8'(text_q.pop_front());
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata <= next_byte;
    end

    // ---------------- receiver stall pattern ----------------
    int stall_phase = 0;

    always @(posedge aclk) begin
        logic rdy;
        stall_phase <= (stall_phase + 1) % 300;
        if (stall_phase < 100) rdy = 1'b1;
        else if (stall_phase < 200) rdy = 1'($urandom_range(0, 1));
        else rdy = (stall_phase % 7) < 2;
        m_tready <= aresetn && rdy;
    end

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        token_beat_t seen, want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.r.kind = m_tdata[2:0];
            seen.r.err  = m_tdata[5:3];
            seen.r.pos  = m_tdata[29:6];
            seen.r.line = m_tdata[53:30];
            seen.r.col  = m_tdata[69:54];
            seen.r.len  = m_tdata[85:70];
            seen.r.val  = m_tdata[148:86];
            seen.r.cv   = m_tdata[156:149];
            seen.last   = m_tlast;
            if (token_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: kind=%0d err=%0d pos=%0d line=%0d col=%0d",
                             seen.r.kind, seen.r.err, seen.r.pos, seen.r.line, seen.r.col);
            end else begin
                want = token_q.pop_front();
                if (seen.r != want.r || seen.last != want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("exp: kind=%0d err=%0d pos=%0d line=%0d col=%0d len=%0d val=%0d cv=%h last=%b",
                                 want.r.kind, want.r.err, want.r.pos, want.r.line, want.r.col,
                                 want.r.len, want.r.val, want.r.cv, want.last);
                        $display("got: kind=%0d err=%0d pos=%0d line=%0d col=%0d len=%0d val=%0d cv=%h last=%b",
                                 seen.r.kind, seen.r.err, seen.r.pos, seen.r.line, seen.r.col,
                                 seen.r.len, seen.r.val, seen.r.cv, seen.last);
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("c_like_source_tokenizer: mismatch");
            $finish;
        end
    end

    initial begin
        lexer_clear();
        // directed text: every token class, diagnostics and CR LF handling
        push_text("ab_9 123 0777 0x1fA 0x; 0xg9 089 0.5 1.2 9223372036854775808 ");
        push_text("0xFFFFFFFFFFFFFFFFF \"hi\" \"\" 'a' '' 'abc' a<<=b>>c->f++");
        push_text(" != ! && += ~#,;?@()[]{} `$");
        text_q.push_back(8'h80);
        text_q.push_back(8'hFF);
        push_text(" /* /* */ */ //x\r\nq\rw\n");
        text_q.push_back(0);
        text_q.push_back(-1);
        push_text("\"o");
        text_q.push_back(0);
        push_text("'k");
        text_q.push_back(0);
        push_text("'ab");
        text_q.push_back(0);
        push_text("/*");
        text_q.push_back(0);
        push_text("//");
        text_q.push_back(0);
        // random token stream with the occasional end of text
        while (text_q.size() < 215) begin
            push_random_token();
            if ($urandom_range(0, 150) == 0) text_q.push_back(-1);
        end
        text_q.push_back(0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        wait (text_q.size() == 0 && !s_tvalid && token_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && token_q.size() == 0) begin
            $display("c_like_source_tokenizer: match");
        end else begin
            $display("c_like_source_tokenizer: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
src/clst_pkg.sv
src/c_like_source_tokenizer.sv
bench/testbench.sv
